@@ hw/rtl/mse_pkg.sv @@
// Package of types, constants and lookup functions for the Morse symbol encoder.
`default_nettype none
package mse_pkg;

	localparam int unsigned VALUE_W = 7;
	localparam int unsigned DOT_W   = 10;
	localparam int unsigned FREQ_W  = 15;
	localparam int unsigned TONE_W  = 12;
	localparam int unsigned GAP_W   = 13;
	localparam int unsigned CODE_W  = 6;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_DOT_TIME  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TONE_FREQ = 2'd1;

	localparam logic [DOT_W-1:0]  DOT_TIME_RST  = 10'd50;
	localparam logic [FREQ_W-1:0] TONE_FREQ_RST = 15'd1500;

	localparam logic [VALUE_W-1:0] CODE_SLASH  = 7'd36;
	localparam logic [VALUE_W-1:0] CODE_LSPACE = 7'd37;
	localparam logic [VALUE_W-1:0] CODE_WSPACE = 7'd38;
	localparam logic [VALUE_W-1:0] NUM_BASE    = 7'd10;
	localparam logic [VALUE_W-1:0] NUM_LIMIT   = 7'd100;

	// Element lengths in dot units.
	localparam logic [2:0] DOT_UNITS    = 3'd1;
	localparam logic [2:0] DASH_UNITS   = 3'd3;
	localparam logic [2:0] DIGIT_UNITS  = 3'd4;
	localparam logic [2:0] LSPACE_UNITS = 3'd3;
	localparam logic [2:0] WSPACE_UNITS = 3'd5;

	localparam logic OP_NUMBER = 1'b0;
	localparam logic OP_SYMBOL = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		KIND_SYM,
		KIND_BAD,
		KIND_LSPACE,
		KIND_WSPACE
	} elem_kind_t;

	// Pattern is first element in the top bit, a one marks a dash.
	typedef struct packed {
		logic [2:0] len;
		logic [4:0] pat;
	} sym_t;

	function automatic sym_t sym_lookup(input logic [CODE_W-1:0] code);
		sym_t s;
		case (code)
			6'd0:  s = '{3'd5, 5'b11111};
			6'd1:  s = '{3'd5, 5'b01111};
			6'd2:  s = '{3'd5, 5'b00111};
			6'd3:  s = '{3'd5, 5'b00011};
			6'd4:  s = '{3'd5, 5'b00001};
			6'd5:  s = '{3'd5, 5'b00000};
			6'd6:  s = '{3'd5, 5'b10000};
			6'd7:  s = '{3'd5, 5'b11000};
			6'd8:  s = '{3'd5, 5'b11100};
			6'd9:  s = '{3'd5, 5'b11110};
			6'd10: s = '{3'd2, 5'b01000};
			6'd11: s = '{3'd4, 5'b10000};
			6'd12: s = '{3'd4, 5'b10100};
			6'd13: s = '{3'd3, 5'b10000};
			6'd14: s = '{3'd1, 5'b00000};
			6'd15: s = '{3'd4, 5'b00100};
			6'd16: s = '{3'd3, 5'b11000};
			6'd17: s = '{3'd4, 5'b00000};
			6'd18: s = '{3'd2, 5'b00000};
			6'd19: s = '{3'd4, 5'b01110};
			6'd20: s = '{3'd3, 5'b10100};
			6'd21: s = '{3'd4, 5'b01000};
			6'd22: s = '{3'd2, 5'b11000};
			6'd23: s = '{3'd2, 5'b10000};
			6'd24: s = '{3'd3, 5'b11100};
			6'd25: s = '{3'd4, 5'b01100};
			6'd26: s = '{3'd4, 5'b11010};
			6'd27: s = '{3'd3, 5'b01000};
			6'd28: s = '{3'd3, 5'b00000};
			6'd29: s = '{3'd1, 5'b10000};
			6'd30: s = '{3'd3, 5'b00100};
			6'd31: s = '{3'd4, 5'b00010};
			6'd32: s = '{3'd3, 5'b01100};
			6'd33: s = '{3'd4, 5'b10010};
			6'd34: s = '{3'd4, 5'b10110};
			6'd35: s = '{3'd4, 5'b11000};
			6'd36: s = '{3'd5, 5'b10010};
			default: s = '{3'd1, 5'b00000};
		endcase
		return s;
	endfunction

	// Tens digit of a number below 100: multiply by 205/2048.
	function automatic logic [3:0] tens_of(input logic [VALUE_W-1:0] v);
		logic [14:0] p;
		p = 15'(v) * 15'd205;
		return p[14:11];
	endfunction

	// Dot time scaled by a small unit count with shifts and adds.
	function automatic logic [GAP_W-1:0] scale_dot(input logic [DOT_W-1:0] dot,
			input logic [2:0] units);
		logic [GAP_W-1:0] d;
		d = GAP_W'(dot);
		return (units[2] ? (d << 2) : '0) + (units[1] ? (d << 1) : '0) +
			(units[0] ? d : '0);
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/mse_ifs.sv @@
// Channel interfaces of the Morse symbol encoder: input items, elements and configuration.
`default_nettype none
interface mse_in_if import mse_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               op;
	logic [VALUE_W-1:0] value;
	modport source (output valid, output op, output value, input ready);
	modport sink (input valid, input op, input value, output ready);
endinterface

interface mse_out_if import mse_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              tone_on;
	logic [TONE_W-1:0] tone_time;
	logic [GAP_W-1:0]  gap_time;
	logic [FREQ_W-1:0] freq_out;
	logic              bad_code;
	logic              last;
	modport source (output valid, output tone_on, output tone_time, output gap_time,
		output freq_out, output bad_code, output last, input ready);
	modport sink (input valid, input tone_on, input tone_time, input gap_time,
		input freq_out, input bad_code, input last, output ready);
endinterface

interface mse_cfg_if import mse_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [FREQ_W-1:0]    data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/morse_symbol_encoder.sv @@
// Top level of the Morse symbol encoder: decoder, element sequencer and output register.
//
// An item on sym_in is either a number 0..99 (op 0) or a symbol code (op 1):
// digits 0-9, letters a-z as 10-35, slash 36, letter space 37, word space 38.
// Each item gives a run of elements on elem_out, the final one marked last.
// A tone element lasts one dot or three dots and is followed by a one-dot gap;
// the last element of a tens digit carries a four-dot gap. Letter and word
// spaces give one pure-gap element of three or five dots. Out-of-range input
// gives one element with bad_code set.
// Sequence: the item is taken in ST_IDLE, decoded in ST_DECODE in the next cycle,
// and elements then leave one per cycle from the output register while the
// receiver does not stall, up to ten per item. The element sequencer, which
// uses two shift-add dot scalers, sets that pace.
// sym_in.ready is high only while the sequencer is idle.
// When the receiver stalls the output register holds and the sequencer waits.
// The cfg channel is always ready: index 0 writes dot_time, index 1 writes
// tone_freq and other indexes are ignored; write it only when idle.
// Reset clears the sequencer and sets dot_time to 50 and tone_freq to 1500.
`default_nettype none
module morse_symbol_encoder import mse_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	mse_in_if.sink     sym_in,
	mse_out_if.source  elem_out,
	mse_cfg_if.sink    cfg
);

	state_t             state_q, state_d;
	logic [DOT_W-1:0]   dot_time_q;
	logic [FREQ_W-1:0]  tone_freq_q;
	logic               op_q;
	logic [VALUE_W-1:0] value_q;

	elem_kind_t         kind_q;
	logic [4:0]         pat_q;
	logic [2:0]         cnt_q;
	logic [4:0]         pat_b_q;
	logic [2:0]         len_b_q;
	logic               two_q;

	logic               out_valid_q;
	logic               tone_on_q;
	logic [TONE_W-1:0]  tone_time_q;
	logic [GAP_W-1:0]   gap_time_q;
	logic               bad_q;
	logic               last_q;

	logic               accept;
	logic               slot_free;
	logic               emit;
	logic               sym_end;
	logic               run_done;

	// Decode signals.
	logic               dec_bad;
	logic [3:0]         dec_tens;
	logic [VALUE_W-1:0] dec_units;
	logic               dec_two;
	logic [CODE_W-1:0]  dec_code_a;
	sym_t               dec_sym_a, dec_sym_b;
	elem_kind_t         dec_kind;

	// Element values.
	logic [2:0]         tone_units, gap_units;
	logic [GAP_W-1:0]   tone_scaled, gap_scaled;

	assign accept    = sym_in.valid && sym_in.ready;
	assign slot_free = !out_valid_q || elem_out.ready;
	assign sym_in.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	always_comb begin
		dec_bad = (op_q == OP_SYMBOL) ? (value_q > CODE_WSPACE) : (value_q >= NUM_LIMIT);
		dec_tens = tens_of(value_q);
		dec_units = value_q - (VALUE_W'(dec_tens) << 3) - (VALUE_W'(dec_tens) << 1);
		dec_two = (op_q == OP_NUMBER) && (value_q >= NUM_BASE) && !dec_bad;
		dec_code_a = dec_two ? CODE_W'(dec_tens) : value_q[CODE_W-1:0];
		dec_sym_a = sym_lookup(dec_code_a);
		dec_sym_b = sym_lookup(dec_units[CODE_W-1:0]);
		if (dec_bad) begin
			dec_kind = KIND_BAD;
		end else if (op_q == OP_SYMBOL && value_q == CODE_LSPACE) begin
			dec_kind = KIND_LSPACE;
		end else if (op_q == OP_SYMBOL && value_q == CODE_WSPACE) begin
			dec_kind = KIND_WSPACE;
		end else begin
			dec_kind = KIND_SYM;
		end
	end

	// Two shift-add scalers turn the unit counts of the current element into ms.
	always_comb begin
		sym_end = (cnt_q == 3'd1);
		case (kind_q)
			KIND_SYM: begin
				tone_units = pat_q[4] ? DASH_UNITS : DOT_UNITS;
				gap_units  = (sym_end && two_q) ? DIGIT_UNITS : DOT_UNITS;
			end
			KIND_LSPACE: begin
				tone_units = 3'd0;
				gap_units  = LSPACE_UNITS;
			end
			KIND_WSPACE: begin
				tone_units = 3'd0;
				gap_units  = WSPACE_UNITS;
			end
			default: begin
				tone_units = 3'd0;
				gap_units  = 3'd0;
			end
		endcase
		tone_scaled = scale_dot(dot_time_q, tone_units);
		gap_scaled  = scale_dot(dot_time_q, gap_units);
	end

	always_comb begin
		state_d  = state_q;
		emit     = 1'b0;
		run_done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free) begin
					emit = 1'b1;
					run_done = (kind_q != KIND_SYM) || (sym_end && !two_q);
					if (run_done) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			dot_time_q  <= DOT_TIME_RST;
			tone_freq_q <= TONE_FREQ_RST;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (elem_out.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_DOT_TIME:  dot_time_q  <= cfg.data[DOT_W-1:0];
					REG_TONE_FREQ: tone_freq_q <= cfg.data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= sym_in.op;
			value_q <= sym_in.value;
		end
		if (state_q == ST_DECODE) begin
			kind_q  <= dec_kind;
			pat_q   <= dec_sym_a.pat;
			cnt_q   <= dec_sym_a.len;
			pat_b_q <= dec_sym_b.pat;
			len_b_q <= dec_sym_b.len;
			two_q   <= dec_two;
		end else if (emit && kind_q == KIND_SYM) begin
			if (sym_end) begin
				// Tens digit finished: carry on with the units digit.
				pat_q <= pat_b_q;
				cnt_q <= len_b_q;
				two_q <= 1'b0;
			end else begin
				pat_q <= {pat_q[3:0], 1'b0};
				cnt_q <= cnt_q - 3'd1;
			end
		end
		if (emit) begin
			tone_on_q   <= (kind_q == KIND_SYM);
			tone_time_q <= tone_scaled[TONE_W-1:0];
			gap_time_q  <= gap_scaled;
			bad_q       <= (kind_q == KIND_BAD);
			last_q      <= run_done;
		end
	end

	assign elem_out.valid     = out_valid_q;
	assign elem_out.tone_on   = tone_on_q;
	assign elem_out.tone_time = tone_time_q;
	assign elem_out.gap_time  = gap_time_q;
	assign elem_out.freq_out  = tone_freq_q;
	assign elem_out.bad_code  = bad_q;
	assign elem_out.last      = last_q;

	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_DECODE)
		else $error("accepted item was not decoded next");

	a_bad_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && bad_q) |-> (last_q && !tone_on_q))
		else $error("flagged element is not a lone final gap");

	a_no_input_while_emitting: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> !sym_in.ready)
		else $error("input taken while a run is being sent");

	a_last_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && run_done) |=> (state_q == ST_IDLE && out_valid_q && last_q))
		else $error("final element did not end the run");

endmodule
`default_nettype wire
